/* rtl/affc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Affine cipher package
// Shared types, register indexes, operation codes and the control store of
// the affine cipher symbol core.
// ----------------------------------------------------------------------------
package affc_pkg;

   // Field widths of the words on the ports.
   localparam int SYM_W = 8;
   localparam int KEY_W = 8;
   localparam int VAL_W = 9;   // width of the modulus and of every residue

   typedef logic [VAL_W-1:0] val_type;
   typedef logic [VAL_W:0]   wide_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_KEY_BAD = 2'd1,
      STATUS_SYM_BAD = 2'd2
   } status_type;

   typedef struct packed {
      logic             mode;
      logic [SYM_W-1:0] symbol;
   } req_type;

   typedef struct packed {
      logic [SYM_W-1:0] result_symbol;
      status_type       status;
   } rsp_type;

   // Configuration register indexes.
   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_MULT_KEY      = 2'd0;
   localparam csr_index_type CSR_SHIFT_KEY     = 2'd1;
   localparam csr_index_type CSR_ALPHABET_SIZE = 2'd2;

   // Datapath operations, one per control word.
   typedef enum logic [3:0] {
      OP_NOP,
      OP_START,
      OP_DIV_M,
      OP_EU_INIT,
      OP_DIV_EU,
      OP_EU_UPD,
      OP_LD_ENC,
      OP_LD_DEC,
      OP_MUL,
      OP_FINISH,
      OP_OUT_OK,
      OP_OUT_KEY,
      OP_OUT_SYM
   } op_type;

   // Branch conditions tested by the sequencer.
   typedef enum logic [3:0] {
      C_ALWAYS,
      C_REQ,
      C_CNT_NZ,
      C_KEY_BAD,
      C_R1_ZERO,
      C_GCD_NOT1,
      C_SYM_BAD,
      C_DECRYPT,
      C_OUT_BLOCKED
   } cond_type;

   typedef logic [3:0] upc_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      upc_type  jump;    // taken when the condition holds
      upc_type  next;    // taken otherwise
   } ctrl_word_type;

   typedef struct packed {
      logic cnt_nz;
      logic r1_zero;
      logic gcd_not1;
      logic sym_bad;
      logic decrypt;
   } dp_flags_type;

   // Control store addresses.
   localparam upc_type UA_IDLE     = 4'd0;
   localparam upc_type UA_AMOD     = 4'd1;
   localparam upc_type UA_EU_INIT  = 4'd2;
   localparam upc_type UA_EU_HEAD  = 4'd3;
   localparam upc_type UA_EU_DIV   = 4'd4;
   localparam upc_type UA_EU_UPD   = 4'd5;
   localparam upc_type UA_GCD_CHK  = 4'd6;
   localparam upc_type UA_SYM_CHK  = 4'd7;
   localparam upc_type UA_MODE     = 4'd8;
   localparam upc_type UA_LD_DEC   = 4'd9;
   localparam upc_type UA_MUL      = 4'd10;
   localparam upc_type UA_FINISH   = 4'd11;
   localparam upc_type UA_OUT_OK   = 4'd12;
   localparam upc_type UA_FAIL_KEY = 4'd13;
   localparam upc_type UA_FAIL_SYM = 4'd14;

   function automatic ctrl_word_type ucode_rom(input upc_type upc);
      ctrl_word_type w;
      w = '{OP_NOP, C_ALWAYS, UA_IDLE, UA_IDLE};
      case (upc)
         UA_IDLE:     w = '{OP_START,   C_REQ,         UA_AMOD,     UA_IDLE};
         UA_AMOD:     w = '{OP_DIV_M,   C_CNT_NZ,      UA_AMOD,     UA_EU_INIT};
         UA_EU_INIT:  w = '{OP_EU_INIT, C_KEY_BAD,     UA_FAIL_KEY, UA_EU_HEAD};
         UA_EU_HEAD:  w = '{OP_NOP,     C_R1_ZERO,     UA_GCD_CHK,  UA_EU_DIV};
         UA_EU_DIV:   w = '{OP_DIV_EU,  C_CNT_NZ,      UA_EU_DIV,   UA_EU_UPD};
         UA_EU_UPD:   w = '{OP_EU_UPD,  C_ALWAYS,      UA_EU_HEAD,  UA_EU_HEAD};
         UA_GCD_CHK:  w = '{OP_NOP,     C_GCD_NOT1,    UA_FAIL_KEY, UA_SYM_CHK};
         UA_SYM_CHK:  w = '{OP_NOP,     C_SYM_BAD,     UA_FAIL_SYM, UA_MODE};
         UA_MODE:     w = '{OP_LD_ENC,  C_DECRYPT,     UA_LD_DEC,   UA_MUL};
         UA_LD_DEC:   w = '{OP_LD_DEC,  C_ALWAYS,      UA_MUL,      UA_MUL};
         UA_MUL:      w = '{OP_MUL,     C_CNT_NZ,      UA_MUL,      UA_FINISH};
         UA_FINISH:   w = '{OP_FINISH,  C_ALWAYS,      UA_OUT_OK,   UA_OUT_OK};
         UA_OUT_OK:   w = '{OP_OUT_OK,  C_OUT_BLOCKED, UA_OUT_OK,   UA_IDLE};
         UA_FAIL_KEY: w = '{OP_OUT_KEY, C_OUT_BLOCKED, UA_FAIL_KEY, UA_IDLE};
         UA_FAIL_SYM: w = '{OP_OUT_SYM, C_OUT_BLOCKED, UA_FAIL_SYM, UA_IDLE};
         default:     w = '{OP_NOP,     C_ALWAYS,      UA_IDLE,     UA_IDLE};
      endcase
      return w;
   endfunction

endpackage

/* rtl/affc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Affine cipher datapath
// Shift-subtract divider and modular double-and-add unit, plus the Euclid
// and operand registers, all steered by the current control word.
// ----------------------------------------------------------------------------
module affc_datapath
   import affc_pkg::*;
(
   input  logic             clock,
   input  op_type           op,
   input  req_type          req_data,
   input  logic [KEY_W-1:0] mult_key,
   input  logic [KEY_W-1:0] shift_key,
   input  val_type          alphabet_size,
   output val_type          acc,
   output dp_flags_type     flags
);

   localparam logic [3:0] STEP_LAST = 4'(VAL_W - 1);
   localparam val_type    VAL_ONE   = {{(VAL_W-1){1'b0}}, 1'b1};

   logic             mode_ff, mode_in;
   logic [SYM_W-1:0] sym_ff, sym_in;
   val_type          sh_ff, sh_in;
   val_type          rem_ff, rem_in;
   val_type          acc_ff, acc_in;
   val_type          r0_ff, r0_in;
   val_type          r1_ff, r1_in;
   val_type          t0_ff, t0_in;
   val_type          t1_ff, t1_in;
   val_type          p_ff, p_in;
   logic [3:0]       cnt_ff, cnt_in;

   val_type  m;
   val_type  sym_ext;
   val_type  b_ext;
   val_type  div_sel;
   wide_type rem_shift;
   wide_type rem_diff;
   logic     qbit;
   val_type  rem_step;
   wide_type dbl;
   wide_type dbl_diff;
   val_type  dbl_red;
   logic     add_en;
   val_type  addend;
   wide_type sum;
   wide_type sum_diff;
   val_type  mm_step;
   wide_type bsum;
   wide_type bsum_diff;
   val_type  bsum_red;
   wide_type t_wrap;
   wide_type t_diff;
   val_type  t_new;
   wide_type d_wrap;
   wide_type d_diff;
   val_type  d_shift;

   assign m       = alphabet_size;
   assign sym_ext = {{(VAL_W-SYM_W){1'b0}}, sym_ff};
   assign b_ext   = {{(VAL_W-KEY_W){1'b0}}, shift_key};

   // One restoring division step: the divisor is m when reducing the key,
   // otherwise the current Euclid divisor.
   always_comb begin
      div_sel   = (op == OP_DIV_M) ? m : r1_ff;
      rem_shift = {rem_ff, sh_ff[VAL_W-1]};
      rem_diff  = rem_shift - {1'b0, div_sel};
      qbit      = (rem_shift >= {1'b0, div_sel});
      rem_step  = qbit ? rem_diff[VAL_W-1:0] : rem_shift[VAL_W-1:0];
   end

   // One modular double-and-add step. During Euclid the quotient bits drive
   // it, so it accumulates q*t1 mod m alongside the division.
   always_comb begin
      dbl      = {acc_ff, 1'b0};
      dbl_diff = dbl - {1'b0, m};
      dbl_red  = (dbl >= {1'b0, m}) ? dbl_diff[VAL_W-1:0] : dbl[VAL_W-1:0];
      add_en   = (op == OP_DIV_EU) ? qbit : sh_ff[VAL_W-1];
      addend   = (op == OP_DIV_EU) ? t1_ff : p_ff;
      sum      = {1'b0, dbl_red} + {1'b0, (add_en ? addend : '0)};
      sum_diff = sum - {1'b0, m};
      mm_step  = (sum >= {1'b0, m}) ? sum_diff[VAL_W-1:0] : sum[VAL_W-1:0];
   end

   always_comb begin
      bsum      = {1'b0, acc_ff} + {1'b0, b_ext};
      bsum_diff = bsum - {1'b0, m};
      bsum_red  = (bsum >= {1'b0, m}) ? bsum_diff[VAL_W-1:0] : bsum[VAL_W-1:0];

      t_diff = {1'b0, t0_ff} - {1'b0, acc_ff};
      t_wrap = {1'b0, t0_ff} + {1'b0, m} - {1'b0, acc_ff};
      t_new  = (t0_ff >= acc_ff) ? t_diff[VAL_W-1:0] : t_wrap[VAL_W-1:0];

      d_diff  = {1'b0, sym_ext} - {1'b0, b_ext};
      d_wrap  = {1'b0, sym_ext} + {1'b0, m} - {1'b0, b_ext};
      d_shift = (sym_ext >= b_ext) ? d_diff[VAL_W-1:0] : d_wrap[VAL_W-1:0];
   end

   always_comb begin
      mode_in = mode_ff;
      sym_in  = sym_ff;
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      r0_in   = r0_ff;
      r1_in   = r1_ff;
      t0_in   = t0_ff;
      t1_in   = t1_ff;
      p_in    = p_ff;
      cnt_in  = cnt_ff;
      case (op)
         OP_START: begin
            mode_in = req_data.mode;
            sym_in  = req_data.symbol;
            sh_in   = {{(VAL_W-KEY_W){1'b0}}, mult_key};
            rem_in  = '0;
            cnt_in  = STEP_LAST;
         end
         OP_DIV_M: begin
            rem_in = rem_step;
            sh_in  = {sh_ff[VAL_W-2:0], 1'b0};
            cnt_in = cnt_ff - 4'd1;
         end
         OP_EU_INIT: begin
            r0_in  = m;
            r1_in  = rem_ff;
            p_in   = rem_ff;
            t0_in  = '0;
            t1_in  = VAL_ONE;
            sh_in  = m;
            rem_in = '0;
            acc_in = '0;
            cnt_in = STEP_LAST;
         end
         OP_DIV_EU: begin
            rem_in = rem_step;
            acc_in = mm_step;
            sh_in  = {sh_ff[VAL_W-2:0], 1'b0};
            cnt_in = cnt_ff - 4'd1;
         end
         OP_EU_UPD: begin
            r0_in  = r1_ff;
            r1_in  = rem_ff;
            t0_in  = t1_ff;
            t1_in  = t_new;
            sh_in  = r1_ff;
            rem_in = '0;
            acc_in = '0;
            cnt_in = STEP_LAST;
         end
         OP_LD_ENC: begin
            sh_in  = sym_ext;
            acc_in = '0;
            cnt_in = STEP_LAST;
         end
         OP_LD_DEC: begin
            p_in   = t0_ff;
            sh_in  = d_shift;
            acc_in = '0;
            cnt_in = STEP_LAST;
         end
         OP_MUL: begin
            acc_in = mm_step;
            sh_in  = {sh_ff[VAL_W-2:0], 1'b0};
            cnt_in = cnt_ff - 4'd1;
         end
         OP_FINISH: begin
            if (!mode_ff) begin
               acc_in = bsum_red;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      sym_ff  <= sym_in;
      sh_ff   <= sh_in;
      rem_ff  <= rem_in;
      acc_ff  <= acc_in;
      r0_ff   <= r0_in;
      r1_ff   <= r1_in;
      t0_ff   <= t0_in;
      t1_ff   <= t1_in;
      p_ff    <= p_in;
      cnt_ff  <= cnt_in;
   end

   assign acc            = acc_ff;
   assign flags.cnt_nz   = (cnt_ff != 4'd0);
   assign flags.r1_zero  = (r1_ff == '0);
   assign flags.gcd_not1 = (r0_ff != VAL_ONE);
   assign flags.sym_bad  = (sym_ext >= m);
   assign flags.decrypt  = mode_ff;

endmodule

/* rtl/affine_cipher_symbol_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Affine cipher symbol core
// Encrypts or decrypts one symbol index per word with an affine map modulo a
// configurable alphabet size, under control of a small microprogram.
// ----------------------------------------------------------------------------
// Usage: a request word on req_data carries the mode (0 encrypt, 1 decrypt)
// and a symbol index. It is taken when req_valid is high and req_stall low.
// Each request gives exactly one response word on rsp_data, taken when
// rsp_valid is high and rsp_stall low. The response holds the result symbol
// and a status: ok, invalid key, or symbol out of range (result 0).
// Keys and alphabet size are written through the csr_ port, which is always
// ready; write it only while no request is in flight.
// Sequence: the sequencer works on one word at a time. After the accepting
// edge a word has the multiplier reduced modulo m and Euclid set up, then
// runs the Euclid iterations (each a nine-step shift-subtract division with
// a concurrent modular accumulate), then checks the symbol, multiplies and
// stores the response; encrypt adds b after the multiply, while decrypt
// first subtracts b and loads the inverse in a step of its own. A bad
// modulus or shift returns before Euclid, a multiplier that is not coprime
// after it, and a symbol out of range after the coprimality check.
// The response sits in an output register, so a new request is taken in the
// cycle after the previous result is stored there, even while rsp_stall
// holds it. Reset returns the keys to a=1, b=1, m=26 and empties it.
// ----------------------------------------------------------------------------
module affine_cipher_symbol_core
   import affc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  val_type       csr_data
);

   // Largest alphabet whose symbols fit in the symbol field.
   localparam val_type M_LIMIT = val_type'(1 << SYM_W);

   logic [KEY_W-1:0] mult_key_ff, mult_key_in;
   logic [KEY_W-1:0] shift_key_ff, shift_key_in;
   val_type          alphabet_size_ff, alphabet_size_in;
   upc_type          upc_ff, upc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   ctrl_word_type    cw;
   dp_flags_type     flags;
   val_type          acc;
   logic             key_bad;
   logic             out_free;
   logic             cond_true;

   // The configuration port never pushes back.
   assign csr_ready = 1'b1;

   always_comb begin
      mult_key_in      = mult_key_ff;
      shift_key_in     = shift_key_ff;
      alphabet_size_in = alphabet_size_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MULT_KEY:      mult_key_in      = csr_data[KEY_W-1:0];
            CSR_SHIFT_KEY:     shift_key_in     = csr_data[KEY_W-1:0];
            CSR_ALPHABET_SIZE: alphabet_size_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   // The key is rejected at once when m is out of range or b is not in
   // (0, m); coprimality is settled later by the Euclid loop.
   assign key_bad = (alphabet_size_ff < 9'd2) ||
                    (alphabet_size_ff > M_LIMIT) ||
                    (shift_key_ff == '0) ||
                    ({1'b0, shift_key_ff} >= alphabet_size_ff);

   // The control store is read combinationally from the step counter.
   assign cw = ucode_rom(upc_ff);

   // Requests are taken only while the sequencer sits at its idle step.
   assign req_stall = (upc_ff != UA_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (cw.cond)
         C_ALWAYS:      cond_true = 1'b1;
         C_REQ:         cond_true = req_valid;
         C_CNT_NZ:      cond_true = flags.cnt_nz;
         C_KEY_BAD:     cond_true = key_bad;
         C_R1_ZERO:     cond_true = flags.r1_zero;
         C_GCD_NOT1:    cond_true = flags.gcd_not1;
         C_SYM_BAD:     cond_true = flags.sym_bad;
         C_DECRYPT:     cond_true = flags.decrypt;
         C_OUT_BLOCKED: cond_true = !out_free;
         default:       cond_true = 1'b0;
      endcase
      upc_in = cond_true ? cw.jump : cw.next;
   end

   // Output register: loaded by the three output steps once it has room,
   // emptied when the receiver takes the word.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (out_free) begin
         case (cw.op)
            OP_OUT_OK: begin
               rsp_valid_in         = 1'b1;
               rsp_in.result_symbol = acc[SYM_W-1:0];
               rsp_in.status        = STATUS_OK;
            end
            OP_OUT_KEY: begin
               rsp_valid_in         = 1'b1;
               rsp_in.result_symbol = '0;
               rsp_in.status        = STATUS_KEY_BAD;
            end
            OP_OUT_SYM: begin
               rsp_valid_in         = 1'b1;
               rsp_in.result_symbol = '0;
               rsp_in.status        = STATUS_SYM_BAD;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mult_key_ff      <= 8'd1;
         shift_key_ff     <= 8'd1;
         alphabet_size_ff <= 9'd26;
         upc_ff           <= UA_IDLE;
         rsp_valid_ff     <= 1'b0;
      end else begin
         mult_key_ff      <= mult_key_in;
         shift_key_ff     <= shift_key_in;
         alphabet_size_ff <= alphabet_size_in;
         upc_ff           <= upc_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   affc_datapath u_datapath (
      .clock         (clock),
      .op            (cw.op),
      .req_data      (req_data),
      .mult_key      (mult_key_ff),
      .shift_key     (shift_key_ff),
      .alphabet_size (alphabet_size_ff),
      .acc           (acc),
      .flags         (flags)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* tb/tb_affine_cipher_symbol_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Affine cipher symbol core testbench
// Drives encrypt and decrypt words through the core under many key settings.
// A built-in model predicts every response word, and the responses are
// compared field by field in arrival order. Both handshakes see random gaps
// and stalls, and one stretch of the random part runs without any.
// ----------------------------------------------------------------------------
module tb_affine_cipher_symbol_core;
   import affc_pkg::*;

   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

   // The index field has room for one index past the last register.
   localparam csr_index_type CSR_SPARE = 2'd3;

   localparam int STALL_PCT       = 20;    // percent chance of a request gap or a response stall
   localparam int SETTLE_CYCLES   = 16;    // quiet time before a key change
   localparam int WATCHDOG_LIMIT  = 4000;  // quiet cycles before the watchdog ends the run
   localparam int RANDOM_PHASES   = 28;
   localparam int WORDS_PER_PHASE = 48;

   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_type       req_data  = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_type       rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_MULT_KEY;
   val_type       csr_data  = '0;

   // Our own copy of the key registers, starting at their reset values.
   logic [KEY_W-1:0] mult_key_copy  = 8'd1;
   logic [KEY_W-1:0] shift_key_copy = 8'd1;
   val_type          alphabet_copy  = 9'd26;

   // Response words still owed by the core, oldest first.
   rsp_type     due_words[$];
   bit          steady_run    = 1'b0;
   int unsigned error_count   = 0;
   int unsigned words_sent    = 0;
   int unsigned words_checked = 0;
   int unsigned key_settings  = 0;

   affine_cipher_symbol_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Affine map on one symbol. One pass of extended Euclid on (m, a mod m)
   // yields the gcd in r0 and the inverse coefficient in t0, so the key check
   // and the decrypt inverse come out of the same loop. A key fault outranks
   // a symbol fault, and either one forces the result symbol to zero.
   function automatic rsp_type affine_transform(input logic [KEY_W-1:0] a,
                                                input logic [KEY_W-1:0] b,
                                                input val_type m,
                                                input logic mode,
                                                input logic [SYM_W-1:0] x);
      int      md, ai, bi, xi, am;
      int      r0, r1, t0, t1, q, rn, tn;
      rsp_type y;
      md = int'(m);
      ai = int'(a);
      bi = int'(b);
      xi = int'(x);
      y.result_symbol = '0;
      y.status = STATUS_OK;
      if (md < 2 || md > (1 << SYM_W)) begin
         y.status = STATUS_KEY_BAD;
         return y;
      end
      am = ai % md;
      r0 = md;
      r1 = am;
      t0 = 0;
      t1 = 1;
      while (r1 != 0) begin
         q  = r0 / r1;
         rn = r0 - q * r1;
         tn = t0 - q * t1;
         r0 = r1;
         r1 = rn;
         t0 = t1;
         t1 = tn;
      end
      if (r0 != 1 || bi == 0 || bi >= md) begin
         y.status = STATUS_KEY_BAD;
      end else if (xi >= md) begin
         y.status = STATUS_SYM_BAD;
      end else if (mode == MODE_ENCRYPT) begin
         y.result_symbol = SYM_W'((am * xi + bi) % md);
      end else begin
         t0 = t0 % md;
         if (t0 < 0) t0 = t0 + md;
         y.result_symbol = SYM_W'((t0 * ((xi + md - bi) % md)) % md);
      end
      return y;
   endfunction

   // Sends one request word, possibly after a random gap. The valid stays
   // high on return so that back-to-back words never drop it for a step.
   task automatic send_word(input logic mode, input logic [SYM_W-1:0] symbol);
      rsp_type want;
      int      gap;
      if (!steady_run && $urandom_range(99) < STALL_PCT) begin
         gap = int'($urandom_range(1, 40));
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      want = affine_transform(mult_key_copy, shift_key_copy, alphabet_copy, mode, symbol);
      req_valid <= 1'b1;
      req_data  <= '{mode: mode, symbol: symbol};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      due_words.push_back(want);
      words_sent++;
   endtask

   // Drops the request valid and waits until every owed word has come back,
   // plus a few cycles so the sequencer is back in its idle state.
   task automatic settle();
      req_valid <= 1'b0;
      while (due_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input val_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      // Key registers keep only their low byte; the spare index changes nothing.
      case (idx)
         CSR_MULT_KEY:      mult_key_copy  = data[KEY_W-1:0];
         CSR_SHIFT_KEY:     shift_key_copy = data[KEY_W-1:0];
         CSR_ALPHABET_SIZE: alphabet_copy  = data;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_keys(input val_type a, input val_type b, input val_type m);
      settle();
      write_reg(CSR_MULT_KEY, a);
      write_reg(CSR_SHIFT_KEY, b);
      write_reg(CSR_ALPHABET_SIZE, m);
      key_settings++;
   endtask

   // Reset keys are a=1, b=1, m=26: a plain shift by one.
   task automatic test_reset_keys();
      send_word(MODE_ENCRYPT, 8'd0);
      send_word(MODE_ENCRYPT, 8'd25);
      send_word(MODE_ENCRYPT, 8'd26);
      send_word(MODE_DECRYPT, 8'd0);
      send_word(MODE_DECRYPT, 8'd25);
      send_word(MODE_DECRYPT, 8'd255);
   endtask

   task automatic test_key_faults();
      set_keys(9'd13, 9'd5, 9'd26);     // multiplier shares a factor with m
      send_word(MODE_ENCRYPT, 8'd3);
      set_keys(9'd3, 9'd0, 9'd26);      // zero shift
      send_word(MODE_ENCRYPT, 8'd3);
      set_keys(9'd3, 9'd26, 9'd26);     // shift equal to m
      send_word(MODE_DECRYPT, 8'd3);
      set_keys(9'd0, 9'd1, 9'd7);       // zero multiplier
      send_word(MODE_ENCRYPT, 8'd2);
      set_keys(9'd9, 9'd2, 9'd9);       // multiplier a multiple of m
      send_word(MODE_DECRYPT, 8'd1);
      set_keys(9'd1, 9'd1, 9'd0);       // alphabet sizes below two
      send_word(MODE_ENCRYPT, 8'd0);
      set_keys(9'd1, 9'd1, 9'd1);
      send_word(MODE_DECRYPT, 8'd0);
      set_keys(9'd1, 9'd1, 9'd257);     // alphabet larger than the symbol space
      send_word(MODE_ENCRYPT, 8'd0);
      set_keys(9'd1, 9'd1, 9'd511);
      send_word(MODE_DECRYPT, 8'd255);
      set_keys(9'd2, 9'd1, 9'd26);      // bad key and bad symbol together
      send_word(MODE_ENCRYPT, 8'd200);
   endtask

   task automatic test_edges();
      set_keys(9'd255, 9'd255, 9'd256); // largest alphabet and keys
      send_word(MODE_ENCRYPT, 8'd0);
      send_word(MODE_ENCRYPT, 8'd255);
      send_word(MODE_DECRYPT, 8'd0);
      send_word(MODE_DECRYPT, 8'd255);
      set_keys(9'd1, 9'd1, 9'd2);       // smallest alphabet
      send_word(MODE_ENCRYPT, 8'd0);
      send_word(MODE_DECRYPT, 8'd1);
      send_word(MODE_ENCRYPT, 8'd2);
      set_keys(9'd200, 9'd3, 9'd7);     // multiplier above m is reduced first
      send_word(MODE_ENCRYPT, 8'd6);
      send_word(MODE_DECRYPT, 8'd6);
      // Bit 8 of the data is dropped by the key registers, and a write to
      // the spare index must leave all keys alone.
      set_keys(9'h105, 9'h103, 9'd11);
      write_reg(CSR_SPARE, 9'h1FF);
      send_word(MODE_ENCRYPT, 8'd10);
      send_word(MODE_DECRYPT, 8'd10);
   endtask

   // Random key phases. Most use a valid key so that the words go all the way
   // through Euclid and the multiply; the rest write arbitrary register values.
   task automatic test_random_traffic();
      int               m, sym_top;
      logic [KEY_W-1:0] a8, b8;
      val_type          a_word, b_word, m_word;
      logic             mode;
      logic [SYM_W-1:0] symbol;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if ($urandom_range(99) < 80) begin
            m = int'($urandom_range(2, 1 << SYM_W));
            do begin
               a8 = KEY_W'($urandom_range(0, (1 << KEY_W) - 1));
            end while (affine_transform(a8, 8'd1, val_type'(m), MODE_ENCRYPT, '0).status
                       == STATUS_KEY_BAD);
            b8 = KEY_W'($urandom_range(1, m - 1));
            a_word = {1'($urandom_range(0, 1)), a8};
            b_word = {1'($urandom_range(0, 1)), b8};
            m_word = val_type'(m);
         end else begin
            a_word = val_type'($urandom_range(0, 511));
            b_word = val_type'($urandom_range(0, 511));
            m_word = val_type'($urandom_range(0, 511));
         end
         set_keys(a_word, b_word, m_word);
         // One phase runs with no gaps or stalls on either side.
         steady_run = (phase == RANDOM_PHASES / 3);
         m = int'(alphabet_copy);
         sym_top = (m >= 2 && m <= (1 << SYM_W)) ? m - 1 : (1 << SYM_W) - 1;
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            mode = 1'($urandom_range(0, 1));
            if ($urandom_range(99) < 85) symbol = SYM_W'($urandom_range(0, sym_top));
            else symbol = SYM_W'($urandom_range(0, (1 << SYM_W) - 1));
            send_word(mode, symbol);
         end
         steady_run = 1'b0;
      end
   endtask

   // The response side stalls at random except during the steady stretch.
   always @(posedge clock) begin
      rsp_stall <= !steady_run && ($urandom_range(99) < STALL_PCT);
   end

   // Every accepted response word is compared with the oldest owed word.
   always @(posedge clock) begin : check_responses
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_words.size() == 0) begin
            $error("unexpected response word: result_symbol %0d, status %0d",
                   rsp_data.result_symbol, rsp_data.status);
            error_count++;
         end else begin
            want = due_words.pop_front();
            words_checked++;
            if (rsp_data.result_symbol !== want.result_symbol) begin
               $error("result_symbol: expected %0d, actual %0d",
                      want.result_symbol, rsp_data.result_symbol);
               error_count++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               error_count++;
            end
         end
      end
   end

   // Ends the run when no word moves on any port for too long, which also
   // catches a response that never arrives.
   initial begin : watchdog
      int dead_cycles;
      dead_cycles = 0;
      while (dead_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) dead_cycles = 0;
         else dead_cycles++;
      end
      $display("tb_affine_cipher_symbol_core: done, errors");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_keys();
      test_key_faults();
      test_edges();
      test_random_traffic();
      settle();
      $display("Covered %0d request words under %0d key settings;", words_sent, key_settings);
      $display("%0d response words compared, %0d mismatches.", words_checked, error_count);
      if (error_count == 0) begin
         $display("tb_affine_cipher_symbol_core: done, clean");
      end else begin
         $display("tb_affine_cipher_symbol_core: done, errors");
      end
      $finish;
   end

endmodule
